/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset
`define WSD_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("deframer assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define WSD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Consequent must hold in the cycle after the antecedent
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

/* hdl/wsd_pkg.sv */
// ---------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket deframer modules.
// ---------------------------------------------------------------------------
package wsd_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 63;
  localparam int unsigned OP_W   = 4;

  // Reset value of the maximum extended payload length
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 63'd1048576;

  // Header byte fields
  localparam logic [7:0] HDR_RSV_BITS = 8'h70;
  localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
  localparam logic [7:0] HDR_OP_BITS  = 8'h0F;
  localparam logic [6:0] LEN_EXT16    = 7'h7E;
  localparam logic [6:0] LEN_EXT64    = 7'h7F;

  // Opcodes accepted
  localparam logic [OP_W-1:0] OP_TEXT   = 4'd1;
  localparam logic [OP_W-1:0] OP_BINARY = 4'd2;
  localparam logic [OP_W-1:0] OP_CLOSE  = 4'd8;
  localparam logic [OP_W-1:0] OP_PING   = 4'd9;
  localparam logic [OP_W-1:0] OP_PONG   = 4'd10;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PAYLOAD    = 2'd0,
    ST_HEADER     = 2'd1,
    ST_ERROR      = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  // One input beat
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              buffer_end;
  } beat_t;

  // One result beat
  typedef struct packed {
    status_t           status;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_length;
    logic              last_payload;
  } res_t;

  // True for an opcode the deframer accepts
  function automatic logic op_ok(input logic [OP_W-1:0] op);
    logic ok;
    ok = (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) ||
         (op == OP_PING) || (op == OP_PONG);
    return ok;
  endfunction

endpackage

/* hdl/websocket_frame_deframer_core.sv */
// ---------------------------------------------------------------------------
// websocket_frame_deframer_core
// Client-to-server WebSocket deframer: checks headers, decodes lengths,
// strips the mask and emits one result beat per received byte at most.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid / in_stall  | rx_byte, buffer_end
//  out_    | output    | out_valid / out_stall| status, opcode, payload_byte,
//          |           |                      | payload_length, last_payload
//  cfg_    | input     | cfg_we               | cfg_wdata (max payload length)
//
// One byte is accepted per cycle while in_stall is low. A byte lands in the
// input register, is decoded from there and its result is loaded into the result
// register when the frame logic takes the byte.
// Bytes that give no result still pass through the state machine.
// Reset is synchronous, active low; it returns to the first header byte and
// restores the maximum length to 1048576. No clearing pass is needed.
// A stall on the result side backs up through the input register into
// in_stall in the same cycle.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [62:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_opcode,
  output logic [7:0]  out_payload_byte,
  output logic [62:0] out_payload_length,
  output logic        out_last_payload
);
  import wsd_pkg::*;

  logic  s1_valid;
  beat_t s1_beat;
  logic  take;
  res_t  res;

  // Input register
  wsd_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_buffer_end (in_buffer_end),
    .s1_valid      (s1_valid),
    .s1_beat       (s1_beat),
    .take          (take)
  );

  // Frame state machine and result register
  wsd_frame_fsm u_frame_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_beat   (s1_beat),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Unpack the result beat
  assign out_status         = res.status;
  assign out_opcode         = res.opcode;
  assign out_payload_byte   = res.payload_byte;
  assign out_payload_length = res.payload_length;
  assign out_last_payload   = res.last_payload;

endmodule

/* hdl/wsd_in_stage.sv */
// ---------------------------------------------------------------------------
// wsd_in_stage
// Input register: captures one received beat and holds it until the frame
// logic takes it.
// ---------------------------------------------------------------------------
module wsd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_buffer_end,
  output logic          s1_valid,
  output wsd_pkg::beat_t s1_beat,
  input  logic          take
);
  import wsd_pkg::*;

  logic  valid_r, valid_nxt;
  beat_t beat_r, beat_nxt;
  logic  load;

  // Stall while a held beat cannot move on
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  // Refill whenever the register is free or being emptied
  always_comb begin
    valid_nxt = in_stall ? valid_r : in_valid;
    beat_nxt  = beat_r;
    if (load) begin
      beat_nxt.rx_byte    = in_rx_byte;
      beat_nxt.buffer_end = in_buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    beat_r <= beat_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule

/* hdl/wsd_frame_fsm.sv */
// ---------------------------------------------------------------------------
// wsd_frame_fsm
// Frame state machine: header checks, length decode, mask capture, payload
// unmasking and the registered result beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_frame_fsm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [62:0]    cfg_wdata,
  input  logic           s1_valid,
  input  wsd_pkg::beat_t s1_beat,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output wsd_pkg::res_t  res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       ext_left_r, ext_left_nxt;
  logic [LEN_W-1:0] frame_len_r, frame_len_nxt;
  logic [31:0]      mask_key_r, mask_key_nxt;
  logic [1:0]       mask_idx_r, mask_idx_nxt;
  logic [LEN_W-1:0] payload_left_r, payload_left_nxt;
  logic [OP_W-1:0]  opcode_r, opcode_nxt;
  logic [LEN_W-1:0] max_len_r, max_len_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic             out_ready;
  logic [7:0]       b;
  logic             e;
  logic             do_fail;
  logic             do_pending;
  logic             emit;
  res_t             res_calc;
  phase_t           phase_calc;
  logic [LEN_W-1:0] len_shift;
  logic [7:0]       key_byte;

  // Take a beat when the result register is free or being drained
  assign out_ready = !out_valid_r || !out_stall;
  assign take      = s1_valid && out_ready;

  assign b = s1_beat.rx_byte;
  assign e = s1_beat.buffer_end;

  assign len_shift = {frame_len_r[LEN_W-9:0], b};

  // Pick the key byte for this payload position, first key byte on top
  always_comb begin
    case (mask_idx_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // Decode one beat against the current phase
  always_comb begin
    ext_left_nxt     = ext_left_r;
    frame_len_nxt    = frame_len_r;
    mask_key_nxt     = mask_key_r;
    mask_idx_nxt     = mask_idx_r;
    payload_left_nxt = payload_left_r;
    opcode_nxt       = opcode_r;
    phase_calc       = phase_r;
    do_fail          = 1'b0;
    do_pending       = 1'b0;
    emit             = 1'b0;
    res_calc         = '0;

    case (phase_r)
      PH_HDR0: begin
        if (((b & HDR_RSV_BITS) != 8'h00) || ((b & HDR_TOP_BIT) == 8'h00) ||
            !op_ok(b[3:0] & HDR_OP_BITS[3:0])) begin
          do_fail = 1'b1;
        end else begin
          opcode_nxt = b[3:0];
          phase_calc = PH_HDR1;
          do_pending = 1'b1;
        end
      end
      PH_HDR1: begin
        if ((b & HDR_TOP_BIT) == 8'h00) begin
          do_fail = 1'b1;
        end else begin
          frame_len_nxt = '0;
          mask_idx_nxt  = 2'd0;
          if (b[6:0] == LEN_EXT16) begin
            ext_left_nxt = 4'd2;
            phase_calc   = PH_EXT16;
          end else if (b[6:0] == LEN_EXT64) begin
            ext_left_nxt = 4'd8;
            phase_calc   = PH_EXT64;
          end else begin
            frame_len_nxt = {{(LEN_W-7){1'b0}}, b[6:0]};
            phase_calc    = PH_MASK;
          end
          do_pending = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        if ((phase_r == PH_EXT64) && (ext_left_r == 4'd8) &&
            ((b & HDR_TOP_BIT) != 8'h00)) begin
          do_fail = 1'b1;
        end else begin
          frame_len_nxt = len_shift;
          ext_left_nxt  = ext_left_r - 4'd1;
          if (ext_left_r == 4'd1) begin
            if ((phase_r == PH_EXT64) && (len_shift > max_len_r)) begin
              do_fail = 1'b1;
            end else begin
              mask_idx_nxt = 2'd0;
              phase_calc   = PH_MASK;
              do_pending   = 1'b1;
            end
          end else begin
            do_pending = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_nxt = {mask_key_r[23:0], b};
        if (mask_idx_r != 2'd3) begin
          mask_idx_nxt = mask_idx_r + 2'd1;
          do_pending   = 1'b1;
        end else begin
          mask_idx_nxt     = 2'd0;
          payload_left_nxt = frame_len_r;
          emit             = 1'b1;
          if (frame_len_r == '0) begin
            phase_calc            = PH_HDR0;
            res_calc.status       = ST_HEADER;
            res_calc.opcode       = opcode_r;
            res_calc.last_payload = 1'b1;
          end else if (e) begin
            phase_calc      = PH_HDR0;
            res_calc.status = ST_INCOMPLETE;
          end else begin
            phase_calc              = PH_PAYLOAD;
            res_calc.status         = ST_HEADER;
            res_calc.opcode         = opcode_r;
            res_calc.payload_length = frame_len_r;
          end
        end
      end
      PH_PAYLOAD: begin
        mask_idx_nxt     = mask_idx_r + 2'd1;
        payload_left_nxt = payload_left_r - {{(LEN_W-1){1'b0}}, 1'b1};
        emit             = 1'b1;
        if (payload_left_r == {{(LEN_W-1){1'b0}}, 1'b1}) begin
          phase_calc            = PH_HDR0;
          res_calc.status       = ST_PAYLOAD;
          res_calc.opcode       = opcode_r;
          res_calc.payload_byte = b ^ key_byte;
          res_calc.last_payload = 1'b1;
        end else if (e) begin
          phase_calc      = PH_HDR0;
          res_calc.status = ST_INCOMPLETE;
        end else begin
          res_calc.status       = ST_PAYLOAD;
          res_calc.opcode       = opcode_r;
          res_calc.payload_byte = b ^ key_byte;
        end
      end
      PH_DISCARD: begin
        if (e) begin
          phase_calc = PH_HDR0;
        end
      end
      default: begin
        phase_calc = PH_HDR0;
      end
    endcase

    // Report an error once, then drop to the end of the buffer
    if (do_fail) begin
      phase_calc      = e ? PH_HDR0 : PH_DISCARD;
      emit            = 1'b1;
      res_calc        = '0;
      res_calc.status = ST_ERROR;
    end

    // Buffer end inside the header drops the partial frame
    if (do_pending && e) begin
      phase_calc      = PH_HDR0;
      emit            = 1'b1;
      res_calc        = '0;
      res_calc.status = ST_INCOMPLETE;
    end
  end

  // Commit the beat or hold; drain the result register when it is taken
  always_comb begin
    phase_nxt   = take ? phase_calc : phase_r;
    res_nxt     = take ? res_calc : res_r;
    max_len_nxt = cfg_we ? cfg_wdata : max_len_r;
    if (take) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      out_valid_r <= 1'b0;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      max_len_r   <= max_len_nxt;
    end
    if (take) begin
      ext_left_r     <= ext_left_nxt;
      frame_len_r    <= frame_len_nxt;
      mask_key_r     <= mask_key_nxt;
      mask_idx_r     <= mask_idx_nxt;
      payload_left_r <= payload_left_nxt;
      opcode_r       <= opcode_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // A new result only appears after a beat was taken
  `WSD_ASSERT_IMPLIES(a_rose_after_take, clk, rst_n, $rose(out_valid_r), $past(take))
  // Discarded bytes never produce a result
  `WSD_ASSERT_NEXT(a_discard_silent, clk, rst_n, take && (phase_r == PH_DISCARD), !out_valid_r)
  // Payload phase always has bytes left to count
  `WSD_ASSERT_IMPLIES(a_payload_left, clk, rst_n, phase_r == PH_PAYLOAD, payload_left_r != '0)
  // Empty-frame header carries a zero length
  `WSD_ASSERT_IMPLIES(a_empty_header, clk, rst_n,
    out_valid_r && (res_r.status == ST_HEADER) && res_r.last_payload,
    res_r.payload_length == '0)

endmodule
